// ===== hdl/ttrr_pkg.sv =====
// Shared types and codes for the thread table round-robin scheduler.
`default_nettype none

package ttrr_pkg;

    localparam int MAX_THREADS = 128;
    localparam int IDX_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int VAL_W       = 32;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_CREATE = 3'd1;
    localparam logic [2:0] ACT_JOIN   = 3'd2;
    localparam logic [2:0] ACT_EXIT   = 3'd3;
    localparam logic [2:0] ACT_CANCEL = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOSUCH   = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_DEADLOCK = 3'd4;
    localparam logic [2:0] ST_HALT     = 3'd5;

    typedef struct packed {
        logic [IDX_W-1:0] join_idx;
        logic             joinv;
        logic [IDX_W-1:0] wait_idx;
        logic             waitv;
        logic             cancel;
        logic             zombie;
        logic             valid;
    } entry_t;

    localparam entry_t ENTRY_ROOT = '{
        join_idx: '0, joinv: 1'b0, wait_idx: '0, waitv: 1'b0,
        cancel: 1'b0, zombie: 1'b0, valid: 1'b1
    };

    localparam entry_t ENTRY_NEW = ENTRY_ROOT;

    typedef struct packed {
        logic [2:0]       status;
        logic [IDX_W-1:0] created_thread;
        logic [VAL_W-1:0] join_value;
        logic             join_canceled;
        logic [IDX_W-1:0] woken_thread;
        logic             woken_valid;
    } res_t;

endpackage

`default_nettype wire

// ===== hdl/thread_table_round_robin_scheduler.sv =====
// Top level of the thread table round-robin scheduler.
//
// One input word carries an event on behalf of the running thread: action,
// target_thread and exit_value. One output word answers each event with a
// status, the thread running afterwards and the create, join and wake details.
// Both channels use valid and ready; a word moves when both are high.
// The block takes one event at a time and holds in_ready low while it works.
// A create runs S_CREATE then S_DONE; an unused action code goes to S_DONE.
// Join, exit and cancel read the target and caller entries through the single
// read port of the entry memory, then write back up to two entries in turn.
// Rescheduling walks the entry memory one entry per cycle from the running
// thread onward; ticks end with it, and so do joins and exits that succeed.
// in_ready rises again with out_valid.
// After reset only thread 0 exists and runs; no clearing pass is needed since
// entries beyond the created count read as empty.
// When the receiver stalls the finished word waits in the output register;
// the block still takes one more event, then holds its result and keeps
// in_ready low until the waiting word has been taken.
`default_nettype none

module thread_table_round_robin_scheduler (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [2:0]                  action,
    input  wire logic [ttrr_pkg::IDX_W-1:0]  target_thread,
    input  wire logic [ttrr_pkg::VAL_W-1:0]  exit_value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [2:0]                       status,
    output logic [ttrr_pkg::IDX_W-1:0]       running_thread,
    output logic [ttrr_pkg::IDX_W-1:0]       created_thread,
    output logic [ttrr_pkg::VAL_W-1:0]       join_value,
    output logic                             join_canceled,
    output logic [ttrr_pkg::IDX_W-1:0]       woken_thread,
    output logic                             woken_valid
);

    localparam int IDX_W = ttrr_pkg::IDX_W;
    localparam int CNT_W = ttrr_pkg::CNT_W;
    localparam int VAL_W = ttrr_pkg::VAL_W;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_CREATE = 10'b0000000010,
        S_RDT    = 10'b0000000100,
        S_RDC    = 10'b0000001000,
        S_EVAL   = 10'b0000010000,
        S_WR2    = 10'b0000100000,
        S_RMW_RD = 10'b0001000000,
        S_RMW_WR = 10'b0010000000,
        S_SCAN   = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [CNT_W-1:0]       cc_reg, cc_next;
    logic [CNT_W-1:0]       live_reg, live_next;
    logic                   e0w_reg, e0w_next;
    logic                   s0w_reg, s0w_next;
    logic [CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;

    logic [2:0]             act_reg, act_next;
    logic [IDX_W-1:0]       tgt_reg, tgt_next;
    logic [VAL_W-1:0]       xv_reg, xv_next;
    ttrr_pkg::entry_t       ft_reg, ft_next;
    ttrr_pkg::res_t         res_reg, res_next;
    logic [IDX_W-1:0]       scan_pos_reg, scan_pos_next;
    logic [IDX_W-1:0]       rmw_idx_reg, rmw_idx_next;
    logic                   rmw_scan_reg, rmw_scan_next;
    ttrr_pkg::res_t         out_res_reg, out_res_next;
    logic [IDX_W-1:0]       out_run_reg, out_run_next;

    ttrr_pkg::entry_t       fl_mem [ttrr_pkg::MAX_THREADS];
    logic [VAL_W-1:0]       sv_mem [ttrr_pkg::MAX_THREADS];

    logic                   fl_re, fl_we;
    logic [IDX_W-1:0]       fl_raddr, fl_waddr;
    ttrr_pkg::entry_t       fl_wdata;
    ttrr_pkg::entry_t       fl_q, fl_eff;
    logic                   fl_oob_q, fl_z0_q;
    logic [IDX_W-1:0]       fl_qaddr;

    logic                   sv_re, sv_we;
    logic [IDX_W-1:0]       sv_raddr, sv_waddr;
    logic [VAL_W-1:0]       sv_wdata;
    logic [VAL_W-1:0]       sv_q, sv_eff;
    logic                   sv_oob_q, sv_z0_q;

    logic                   eligible;
    logic [IDX_W-1:0]       scan_addr;

    function automatic logic [IDX_W-1:0] scan_step(input logic [IDX_W-1:0] x,
                                                   input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] s;
        s = {1'b0, x} + CNT_W'(1);
        return (s == n) ? '0 : s[IDX_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            fl_mem[fl_waddr] <= fl_wdata;
        end
        if (fl_re)
        begin
            fl_q     <= fl_mem[fl_raddr];
            fl_oob_q <= ({1'b0, fl_raddr} >= cc_reg);
            fl_z0_q  <= (fl_raddr == '0) && !e0w_reg;
            fl_qaddr <= fl_raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
        begin
            sv_mem[sv_waddr] <= sv_wdata;
        end
        if (sv_re)
        begin
            sv_q     <= sv_mem[sv_raddr];
            sv_oob_q <= ({1'b0, sv_raddr} >= cc_reg);
            sv_z0_q  <= (sv_raddr == '0) && !s0w_reg;
        end
    end

    always_comb
    begin
        if (fl_oob_q)
        begin
            fl_eff = '0;
        end
        else if (fl_z0_q)
        begin
            fl_eff = ttrr_pkg::ENTRY_ROOT;
        end
        else
        begin
            fl_eff = fl_q;
        end
        sv_eff    = (sv_oob_q || sv_z0_q) ? '0 : sv_q;
        eligible  = fl_eff.valid && !fl_eff.zombie && !fl_eff.waitv;
        scan_addr = scan_step(scan_pos_reg, cc_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        cc_next        = cc_reg;
        live_next      = live_reg;
        scan_cnt_next  = scan_cnt_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        act_next       = act_reg;
        tgt_next       = tgt_reg;
        xv_next        = xv_reg;
        ft_next        = ft_reg;
        res_next       = res_reg;
        scan_pos_next  = scan_pos_reg;
        rmw_idx_next   = rmw_idx_reg;
        rmw_scan_next  = rmw_scan_reg;
        out_res_next   = out_res_reg;
        out_run_next   = out_run_reg;
        fl_re          = 1'b0;
        fl_raddr       = tgt_reg;
        fl_we          = 1'b0;
        fl_waddr       = tgt_reg;
        fl_wdata       = '0;
        sv_re          = 1'b0;
        sv_raddr       = tgt_reg;
        sv_we          = 1'b0;
        sv_waddr       = tgt_reg;
        sv_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next      = action;
                    tgt_next      = target_thread;
                    xv_next       = exit_value;
                    res_next      = '0;
                    scan_pos_next = cur_reg;
                    scan_cnt_next = '0;
                    pend_next     = 1'b0;
                    priority if (action == ttrr_pkg::ACT_TICK)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (action == ttrr_pkg::ACT_CREATE)
                    begin
                        state_next = S_CREATE;
                    end
                    else if (action == ttrr_pkg::ACT_JOIN || action == ttrr_pkg::ACT_EXIT ||
                             action == ttrr_pkg::ACT_CANCEL)
                    begin
                        state_next = S_RDT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CREATE:
            begin
                if (cc_reg >= CNT_W'(ttrr_pkg::MAX_THREADS))
                begin
                    res_next.status = ttrr_pkg::ST_FULL;
                end
                else
                begin
                    res_next.created_thread = cc_reg[IDX_W-1:0];
                    fl_we     = 1'b1;
                    fl_waddr  = cc_reg[IDX_W-1:0];
                    fl_wdata  = ttrr_pkg::ENTRY_NEW;
                    sv_we     = 1'b1;
                    sv_waddr  = cc_reg[IDX_W-1:0];
                    sv_wdata  = '0;
                    cc_next   = cc_reg + CNT_W'(1);
                    live_next = live_reg + CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_RDT:
            begin
                fl_re      = 1'b1;
                fl_raddr   = tgt_reg;
                sv_re      = 1'b1;
                sv_raddr   = tgt_reg;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                ft_next    = fl_eff;
                fl_re      = 1'b1;
                fl_raddr   = cur_reg;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                priority if (act_reg == ttrr_pkg::ACT_JOIN)
                begin
                    priority if (!ft_reg.valid)
                    begin
                        res_next.status = ttrr_pkg::ST_NOSUCH;
                    end
                    else if (ft_reg.joinv)
                    begin
                        res_next.status = ttrr_pkg::ST_INVALID;
                    end
                    else if (tgt_reg == cur_reg || (ft_reg.waitv && ft_reg.wait_idx == cur_reg))
                    begin
                        res_next.status = ttrr_pkg::ST_DEADLOCK;
                    end
                    else if (fl_eff.waitv)
                    begin
                        res_next.status = ttrr_pkg::ST_INVALID;
                    end
                    else if (ft_reg.zombie)
                    begin
                        if (ft_reg.cancel)
                        begin
                            res_next.join_canceled = 1'b1;
                        end
                        else
                        begin
                            res_next.join_value = sv_eff;
                        end
                        fl_we      = 1'b1;
                        fl_waddr   = tgt_reg;
                        fl_wdata   = '0;
                        sv_we      = 1'b1;
                        sv_waddr   = tgt_reg;
                        sv_wdata   = '0;
                        live_next  = (live_reg != '0) ? live_reg - CNT_W'(1) : live_reg;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        fl_we             = 1'b1;
                        fl_waddr          = cur_reg;
                        fl_wdata          = fl_eff;
                        fl_wdata.waitv    = 1'b1;
                        fl_wdata.wait_idx = tgt_reg;
                        state_next        = S_WR2;
                    end
                end
                else if (act_reg == ttrr_pkg::ACT_EXIT)
                begin
                    if (live_reg <= CNT_W'(1))
                    begin
                        res_next.status = ttrr_pkg::ST_HALT;
                    end
                    else if (fl_eff.joinv)
                    begin
                        res_next.woken_thread = fl_eff.join_idx;
                        res_next.woken_valid  = 1'b1;
                        fl_we         = 1'b1;
                        fl_waddr      = cur_reg;
                        fl_wdata      = '0;
                        sv_we         = 1'b1;
                        sv_waddr      = cur_reg;
                        sv_wdata      = '0;
                        live_next     = live_reg - CNT_W'(1);
                        rmw_idx_next  = fl_eff.join_idx;
                        rmw_scan_next = 1'b1;
                        state_next    = S_RMW_RD;
                    end
                    else
                    begin
                        fl_we           = 1'b1;
                        fl_waddr        = cur_reg;
                        fl_wdata        = fl_eff;
                        fl_wdata.zombie = 1'b1;
                        sv_we           = (xv_reg != '0);
                        sv_waddr        = cur_reg;
                        sv_wdata        = xv_reg;
                        state_next      = S_SCAN;
                    end
                end
                else
                begin
                    priority if (!ft_reg.valid)
                    begin
                        res_next.status = ttrr_pkg::ST_NOSUCH;
                    end
                    else if (live_reg <= CNT_W'(1))
                    begin
                        res_next.status = ttrr_pkg::ST_HALT;
                    end
                    else
                    begin
                        fl_we           = 1'b1;
                        fl_waddr        = tgt_reg;
                        fl_wdata        = ft_reg;
                        fl_wdata.zombie = 1'b1;
                        fl_wdata.cancel = 1'b1;
                        if (ft_reg.joinv)
                        begin
                            fl_wdata.joinv    = 1'b0;
                            fl_wdata.join_idx = '0;
                            rmw_idx_next      = ft_reg.join_idx;
                            rmw_scan_next     = 1'b0;
                            state_next        = S_RMW_RD;
                        end
                    end
                end
            end
            S_WR2:
            begin
                fl_we             = 1'b1;
                fl_waddr          = tgt_reg;
                fl_wdata          = ft_reg;
                fl_wdata.joinv    = 1'b1;
                fl_wdata.join_idx = cur_reg;
                state_next        = S_SCAN;
            end
            S_RMW_RD:
            begin
                fl_re      = 1'b1;
                fl_raddr   = rmw_idx_reg;
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                fl_we             = 1'b1;
                fl_waddr          = rmw_idx_reg;
                fl_wdata          = fl_eff;
                fl_wdata.waitv    = 1'b0;
                fl_wdata.wait_idx = '0;
                state_next        = rmw_scan_reg ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (pend_reg && eligible)
                begin
                    cur_next   = fl_qaddr;
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (!pend_reg && scan_cnt_reg == cc_reg)
                begin
                    state_next = S_DONE;
                end
                else if (scan_cnt_reg < cc_reg)
                begin
                    fl_re         = 1'b1;
                    fl_raddr      = scan_addr;
                    scan_pos_next = scan_addr;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_res_next   = res_reg;
                    out_run_next   = cur_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        e0w_next = e0w_reg || (fl_we && fl_waddr == '0);
        s0w_next = s0w_reg || (sv_we && sv_waddr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            cc_reg        <= CNT_W'(1);
            live_reg      <= CNT_W'(1);
            e0w_reg       <= 1'b0;
            s0w_reg       <= 1'b0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            cc_reg        <= cc_next;
            live_reg      <= live_next;
            e0w_reg       <= e0w_next;
            s0w_reg       <= s0w_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        tgt_reg      <= tgt_next;
        xv_reg       <= xv_next;
        ft_reg       <= ft_next;
        res_reg      <= res_next;
        scan_pos_reg <= scan_pos_next;
        rmw_idx_reg  <= rmw_idx_next;
        rmw_scan_reg <= rmw_scan_next;
        out_res_reg  <= out_res_next;
        out_run_reg  <= out_run_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign running_thread = out_run_reg;
    assign created_thread = out_res_reg.created_thread;
    assign join_value     = out_res_reg.join_value;
    assign join_canceled  = out_res_reg.join_canceled;
    assign woken_thread   = out_res_reg.woken_thread;
    assign woken_valid    = out_res_reg.woken_valid;

endmodule

`default_nettype wire

// ===== hdl/ttrr_checker.sv =====
// Port-level assertions for the thread table round-robin scheduler and its bind.
`default_nettype none

module ttrr_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [2:0]                  status,
    input wire logic [ttrr_pkg::IDX_W-1:0]  created_thread,
    input wire logic [ttrr_pkg::VAL_W-1:0]  join_value,
    input wire logic                        join_canceled,
    input wire logic                        woken_valid
);

    // A word that waits for the receiver keeps its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("stalled output word changed");

    // The block works on one event at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second event accepted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ttrr_pkg::ST_HALT)
        else $error("status code out of range");

    // A failed event reports no side results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ttrr_pkg::ST_OK |->
            !woken_valid && !join_canceled && join_value == '0 && created_thread == '0)
        else $error("failed event reported side results");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && join_canceled |-> join_value == '0 && !woken_valid)
        else $error("canceled join carried a value");

endmodule

bind thread_table_round_robin_scheduler ttrr_checker u_ttrr_checker (.*);

`default_nettype wire
